### rtl/tsrp_pkg.sv
// Shared types and constants for the round-robin / priority task scheduler.
// Used by tsrp_ctrl, tsrp_datapath and task_scheduler_rr_priority_top.
package tsrp_pkg;

   localparam int MAX_TASKS = 16;
   localparam int SLOT_W    = 4;
   localparam int COUNT_W   = 5;
   localparam int PRIO_W    = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = COUNT_W;

   // Item commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCHED_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_COUNT = 1'd1;

   // Scheduling modes
   localparam logic MODE_RR   = 1'b0;
   localparam logic MODE_PRIO = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic write_en;
      logic scan_init;
      logic mod_en;
      logic scan_en;
   } ctrl_cmd_type;

   typedef struct packed {
      logic mod_done;
      logic scan_done;
   } dp_status_type;

endpackage

### rtl/tsrp_datapath.sv
// Datapath of the task scheduler: task table, running slot, config registers
// and the one-slot-per-cycle scan unit. Depends on tsrp_pkg.
module tsrp_datapath import tsrp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   input  logic [SLOT_W-1:0]     req_task_index,
   input  logic                  req_task_ready,
   input  logic [PRIO_W-1:0]     req_task_priority,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [SLOT_W-1:0]     running_task
);

   logic [MAX_TASKS-1:0] ready_ff, ready_in;
   logic [PRIO_W-1:0]    prio_ff [MAX_TASKS];
   logic [SLOT_W-1:0]    running_ff, running_in;
   logic                 mode_ff, mode_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0]    pos_ff, pos_in;
   logic [SLOT_W-1:0]    step_ff, step_in;
   logic [SLOT_W-1:0]    best_ff, best_in;
   logic [PRIO_W-1:0]    best_prio_ff, best_prio_in;

   logic [COUNT_W-1:0]   slots;
   logic [COUNT_W-1:0]   next_wide;
   logic [SLOT_W-1:0]    next_slot;
   logic                 hit;

   // Clamp the count to 1..MAX_TASKS
   always_comb begin
      if (count_ff == '0) begin
         slots = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(MAX_TASKS)) begin
         slots = COUNT_W'(MAX_TASKS);
      end else begin
         slots = count_ff;
      end
   end

   always_comb begin
      next_wide = {1'b0, pos_ff} + COUNT_W'(1);
      if (mode_ff == MODE_RR && next_wide == slots) begin
         next_slot = '0;
      end else begin
         next_slot = next_wide[SLOT_W-1:0];
      end
      hit = (next_slot != '0) && ready_ff[next_slot];
   end

   always_comb begin
      status.mod_done = (mode_ff == MODE_PRIO) || ({1'b0, pos_ff} < slots);
      if (mode_ff == MODE_RR) begin
         status.scan_done = hit || ({1'b0, step_ff} == slots - COUNT_W'(1));
      end else begin
         status.scan_done = (next_wide >= slots);
      end
   end

   always_comb begin
      ready_in     = ready_ff;
      running_in   = running_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SCHED_MODE: mode_in  = csr_wdata[0];
            CSR_TASK_COUNT: count_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.write_en) begin
         ready_in[req_task_index] = req_task_ready;
      end

      if (cmd.scan_init) begin
         pos_in       = (mode_ff == MODE_RR) ? running_ff : '0;
         step_in      = '0;
         best_in      = '0;
         best_prio_in = '0;
      end

      // Reduce the start position modulo the slot count
      if (cmd.mod_en && !status.mod_done) begin
         pos_in = SLOT_W'({1'b0, pos_ff} - slots);
      end

      if (cmd.scan_en) begin
         pos_in  = next_slot;
         step_in = step_ff + SLOT_W'(1);
         if (mode_ff == MODE_RR) begin
            if (status.scan_done) begin
               running_in = hit ? next_slot : '0;
            end
         end else begin
            if (status.scan_done) begin
               running_in = best_ff;
            end else if (ready_ff[next_slot] && prio_ff[next_slot] > best_prio_ff) begin
               best_in      = next_slot;
               best_prio_in = prio_ff[next_slot];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff   <= '0;
         running_ff <= '0;
         mode_ff    <= MODE_RR;
         count_ff   <= COUNT_W'(1);
         for (int i = 0; i < MAX_TASKS; i++) begin
            prio_ff[i] <= '0;
         end
      end else begin
         ready_ff   <= ready_in;
         running_ff <= running_in;
         mode_ff    <= mode_in;
         count_ff   <= count_in;
         if (cmd.write_en) begin
            prio_ff[req_task_index] <= req_task_priority;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      step_ff      <= step_in;
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
   end

   assign running_task = running_ff;

endmodule

### rtl/tsrp_ctrl.sv
// Controller state machine of the task scheduler: sequences write, modulo
// and scan phases and marks the result beat. Depends on tsrp_pkg.
module tsrp_ctrl import tsrp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_cmd,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_cmd == CMD_WRITE) begin
                  cmd.write_en = 1'b1;
                  state_in     = ST_RESP;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            cmd.mod_en = 1'b1;
            if (status.mod_done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (status.scan_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### rtl/task_scheduler_rr_priority_top.sv
// Top level of the round-robin / static priority task scheduler.
// Depends on tsrp_pkg, tsrp_ctrl and tsrp_datapath.
//
// Usage:
//   Input: drive req_* and raise start; the beat is taken at an edge where
//   start is high and busy is low. req_cmd = write stores ready bit and
//   priority of slot req_task_index; req_cmd = tick picks the next slot.
//   Output: one beat per item, rsp_valid high for exactly one cycle with
//   rsp_running_task holding the running slot (0 is idle). The receiver
//   cannot stall; the beat is gone after that cycle.
//   Config: csr_we writes csr_wdata to register csr_index (0 mode, 1
//   count) at the clock edge. The user must write only while busy is low;
//   the block itself does not enforce it.
// Operation:
//   Write: the result beat comes in the cycle after accept, and busy
//   stays high until that beat is over.
//   Tick: in round-robin mode a modulo phase reduces the running slot
//   modulo n, the slot count, one subtract per cycle; then the scan unit
//   checks one slot per cycle, stopping at the first ready slot or after
//   a full turn in round-robin mode and running to the last slot in
//   priority mode, then the result beat. Busy stays high until it is over.
// Reset: synchronous; clears the task table, running slot goes to idle,
//   mode round-robin, count 1.
module task_scheduler_rr_priority_top import tsrp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic [SLOT_W-1:0]     req_task_index,
   input  logic                  req_task_ready,
   input  logic [PRIO_W-1:0]     req_task_priority,
   output logic                  rsp_valid,
   output logic [SLOT_W-1:0]     rsp_running_task,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   tsrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   tsrp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_task_index    (req_task_index),
      .req_task_ready    (req_task_ready),
      .req_task_priority (req_task_priority),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .running_task      (rsp_running_task)
   );

endmodule
